FILE: rtl/indexed_row_scaler_with_colormap_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed row scaler
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ROW_SCALER_WITH_COLORMAP_ASSERT_SVH
`define INDEXED_ROW_SCALER_WITH_COLORMAP_ASSERT_SVH

// same-cycle property
`define IRSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication
`define IRSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/irsc_pkg.sv
// ----------------------------------------------------------------------------
// irsc_pkg
// Types, constants and helpers shared by the row scaler files.
// ----------------------------------------------------------------------------
package irsc_pkg;

  localparam int MAX_ROW_WIDTH = 4096;
  localparam int MAX_RUN       = 64;

  localparam int LEN_W   = 13;
  localparam int COL_W   = 12;
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 14;
  localparam int K_W     = $clog2(MAX_RUN);
  localparam int THR_W   = CNT_W + K_W;
  localparam int CFG_IDX_W = 4;

  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_LEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TGT_LEN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_EN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_IX = CFG_IDX_W'(3);

  typedef struct packed {
    logic [LEN_W-1:0] src_len;
    logic [LEN_W-1:0] tgt_len;
    logic             trans_en;
    logic [PIX_W-1:0] trans_idx;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic [PIX_W-1:0] wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic             rd_en;
    logic [PIX_W-1:0] rd_addr;
  } map_acc_t;

  // zero acts as one, oversize clamps to the row limit
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_W'(MAX_ROW_WIDTH)) begin
      r = LEN_W'(MAX_ROW_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/irsc_if.sv
// ----------------------------------------------------------------------------
// irsc channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface irsc_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [irsc_pkg::PIX_W-1:0] map_address;
  logic [irsc_pkg::PIX_W-1:0] map_data;
  logic [irsc_pkg::PIX_W-1:0] pixel_index;

  modport source (output valid, req_type, map_address, map_data, pixel_index, input ready);
  modport sink   (input valid, req_type, map_address, map_data, pixel_index, output ready);
endinterface

interface irsc_res_if;
  logic                      valid;
  logic                      ready;
  logic [irsc_pkg::COL_W-1:0] dest_column;
  logic [irsc_pkg::PIX_W-1:0] pixel_value;
  logic                      write_enable;
  logic                      last_of_run;
  logic                      last_of_row;
  logic                      run_truncated;

  modport source (output valid, dest_column, pixel_value, write_enable, last_of_run,
                  last_of_row, run_truncated, input ready);
  modport sink   (input valid, dest_column, pixel_value, write_enable, last_of_run,
                  last_of_row, run_truncated, output ready);
endinterface

interface irsc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [irsc_pkg::CFG_IDX_W-1:0] index;
  logic [irsc_pkg::LEN_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/indexed_row_scaler_with_colormap.sv
// ----------------------------------------------------------------------------
// indexed_row_scaler_with_colormap
// Horizontal nearest-neighbour row scaler with palette colour map.
// ----------------------------------------------------------------------------
// A map-write word or a pixel that yields no output is taken while the block
// stays idle. A pixel that yields a run goes out as one output word per column
// (1 to 64), paced by the output register draining; the request channel is
// held off while the run goes out. A run longer than 64 first goes through
// the iterative divider that finds its full length and remainder.
// The colour map is a 256 x 8 synchronous RAM read once per pixel; an entry
// must be written before a pixel selects it. The user must see that configuration
// is changed only while the block is idle; the block does not enforce this.
module indexed_row_scaler_with_colormap (
  input  logic       clk_i,
  input  logic       rst_ni,
  irsc_cfg_if.sink   cfg_i,
  irsc_req_if.sink   req_i,
  irsc_res_if.source res_o
);
  import irsc_pkg::*;

  cfg_t             cfg_q;
  map_acc_t         map_acc;
  logic [PIX_W-1:0] map_rd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_len   <= LEN_W'(1);
      cfg_q.tgt_len   <= LEN_W'(1);
      cfg_q.trans_en  <= 1'b0;
      cfg_q.trans_idx <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SRC_LEN:  cfg_q.src_len   <= cfg_i.data;
        REG_TGT_LEN:  cfg_q.tgt_len   <= cfg_i.data;
        REG_TRANS_EN: cfg_q.trans_en  <= cfg_i.data[0];
        REG_TRANS_IX: cfg_q.trans_idx <= cfg_i.data[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  irsc_cmap u_cmap (
    .clk_i     (clk_i),
    .acc_i     (map_acc),
    .rd_data_o (map_rd)
  );

  irsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .req        (req_i),
    .res        (res_o),
    .map_o      (map_acc),
    .map_data_i (map_rd)
  );

endmodule

FILE: rtl/irsc_cmap.sv
// ----------------------------------------------------------------------------
// irsc_cmap
// 256-entry colour map, one write and one registered read port.
// ----------------------------------------------------------------------------
module irsc_cmap (
  input  logic                       clk_i,
  input  irsc_pkg::map_acc_t         acc_i,
  output logic [irsc_pkg::PIX_W-1:0] rd_data_o
);
  import irsc_pkg::*;

  logic [PIX_W-1:0] mem_q [2**PIX_W];
  logic [PIX_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (acc_i.wr_en) begin
      mem_q[acc_i.wr_addr] <= acc_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i.rd_en) begin
      rd_q <= mem_q[acc_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: rtl/irsc_div.sv
// ----------------------------------------------------------------------------
// irsc_div
// Restoring divider, one quotient bit per cycle, for long runs.
// ----------------------------------------------------------------------------
`include "indexed_row_scaler_with_colormap_assert.svh"

module irsc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [irsc_pkg::CNT_W-1:0] dividend_i,
  input  logic [irsc_pkg::LEN_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [irsc_pkg::CNT_W-1:0] quot_o,
  output logic [irsc_pkg::LEN_W-1:0] rem_o
);
  import irsc_pkg::*;

  localparam int STEP_W = $clog2(CNT_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  quot_q, quot_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]  trial;
  logic              fits;

  assign trial = {rem_q[CNT_W-2:0], quot_q[CNT_W-1]};
  assign fits  = trial >= CNT_W'(dvs_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(CNT_W - 1);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? (trial - CNT_W'(dvs_q)) : trial;
      quot_d = {quot_q[CNT_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dvs_q  <= LEN_W'(1);
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[LEN_W-1:0];

  `IRSC_ASSERT(a_div_start_idle, !(start_i && busy_q), "divider restarted while busy")
  `IRSC_ASSERT(a_div_rem_small, !done_q || (rem_q < CNT_W'(dvs_q)), "remainder not below divisor")
  `IRSC_ASSERT_NEXT(a_div_start_busy, start_i, busy_q, "divider did not go busy")

endmodule

FILE: rtl/irsc_ctrl.sv
// ----------------------------------------------------------------------------
// irsc_ctrl
// Row sequencer: error accumulator, positions, run emission, output word.
// ----------------------------------------------------------------------------
`include "indexed_row_scaler_with_colormap_assert.svh"

module irsc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  irsc_pkg::cfg_t             cfg_i,
  irsc_req_if.sink                   req,
  irsc_res_if.source                 res,
  output irsc_pkg::map_acc_t         map_o,
  input  logic [irsc_pkg::PIX_W-1:0] map_data_i
);
  import irsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic [COL_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] dest_q, dest_d;

  logic [CNT_W-1:0] t_q, t_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [LEN_W-1:0] acc_dn_q, acc_dn_d;
  logic             down_q, down_d;
  logic             trunc_q, trunc_d;
  logic             trans_q, trans_d;

  logic             ov_q, ov_d;
  logic [COL_W-1:0] o_col_q, o_col_d;
  logic [PIX_W-1:0] o_pix_q, o_pix_d;
  logic             o_we_q, o_we_d;
  logic             o_lrun_q, o_lrun_d;
  logic             o_lrow_q, o_lrow_d;
  logic             o_trunc_q, o_trunc_d;

  logic [LEN_W-1:0] s_len, d_len;
  logic             pix_acc, in_acc;
  logic [CNT_W-1:0] t_up, acc_dn_w, t_sub, col_inc;
  logic             down, down_hit, no_emit, trunc_c, row_done;
  logic [THR_W-1:0] thr;
  logic             out_free, emit, last_w, row_end;
  logic [CNT_W:0]   run_end;
  logic             fin;
  logic [LEN_W-1:0] fin_acc, fin_dest;

  logic             div_done;
  logic [CNT_W-1:0] div_quot;
  logic [LEN_W-1:0] div_rem;

  assign s_len    = eff_len(cfg_i.src_len);
  assign d_len    = eff_len(cfg_i.tgt_len);
  assign req.ready = (state_q == ST_IDLE);
  assign in_acc   = req.valid && req.ready;
  assign pix_acc  = in_acc && (req.req_type == REQ_PIXEL);

  assign down     = s_len > d_len;
  assign down_hit = acc_q < d_len;
  assign t_up     = CNT_W'(acc_q) + CNT_W'(d_len);
  assign acc_dn_w = down_hit ? (CNT_W'(acc_q) + CNT_W'(s_len) - CNT_W'(d_len))
                             : (CNT_W'(acc_q) - CNT_W'(d_len));
  assign no_emit  = down ? !down_hit : (t_up < CNT_W'(s_len));
  assign thr      = THR_W'(s_len) * THR_W'(MAX_RUN + 1);
  assign trunc_c  = !down && (THR_W'(t_up) >= thr);
  assign row_done = (LEN_W'(pos_q) + LEN_W'(1)) >= s_len;

  assign out_free = !ov_q || res.ready;
  assign emit     = (state_q == ST_EMIT) && out_free;
  assign last_w   = trunc_q ? (k_q == K_W'(MAX_RUN - 1)) : (t_q < {s_len, 1'b0});
  assign t_sub    = t_q - CNT_W'(s_len);
  assign col_inc  = col_q + CNT_W'(1);
  assign run_end  = (CNT_W + 1)'(dest_q) + (CNT_W + 1)'(div_quot);
  assign row_end  = (col_inc == CNT_W'(d_len)) ||
                    (last_w && trunc_q && (dest_q < d_len) &&
                     (run_end >= (CNT_W + 1)'(d_len)));

  assign map_o.wr_en   = in_acc && (req.req_type == REQ_MAP);
  assign map_o.wr_addr = req.map_address;
  assign map_o.wr_data = req.map_data;
  assign map_o.rd_en   = pix_acc;
  assign map_o.rd_addr = req.pixel_index;

  irsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pix_acc && !no_emit && trunc_c),
    .dividend_i (t_up),
    .divisor_i  (s_len),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    dest_d    = dest_q;
    t_d       = t_q;
    col_d     = col_q;
    k_d       = k_q;
    acc_dn_d  = acc_dn_q;
    down_d    = down_q;
    trunc_d   = trunc_q;
    trans_d   = trans_q;
    ov_d      = ov_q && !res.ready;
    o_col_d   = o_col_q;
    o_pix_d   = o_pix_q;
    o_we_d    = o_we_q;
    o_lrun_d  = o_lrun_q;
    o_lrow_d  = o_lrow_q;
    o_trunc_d = o_trunc_q;
    fin       = 1'b0;
    fin_acc   = acc_q;
    fin_dest  = dest_q;

    case (state_q)
      ST_IDLE: begin
        if (pix_acc) begin
          trans_d  = cfg_i.trans_en && (req.pixel_index == cfg_i.trans_idx);
          col_d    = CNT_W'(dest_q);
          k_d      = '0;
          down_d   = down;
          acc_dn_d = acc_dn_w[LEN_W-1:0];
          t_d      = down ? CNT_W'(s_len) : t_up;
          if (no_emit) begin
            fin      = 1'b1;
            fin_acc  = down ? acc_dn_w[LEN_W-1:0] : t_up[LEN_W-1:0];
            fin_dest = dest_q;
          end else if (trunc_c) begin
            trunc_d = 1'b1;
            state_d = ST_DIV;
          end else begin
            trunc_d = 1'b0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          ov_d      = 1'b1;
          o_col_d   = col_q[COL_W-1:0];
          o_pix_d   = trans_q ? '0 : map_data_i;
          o_we_d    = !trans_q;
          o_lrun_d  = last_w;
          o_lrow_d  = row_end;
          o_trunc_d = trunc_q;
          col_d     = col_inc;
          k_d       = k_q + K_W'(1);
          t_d       = t_sub;
          if (last_w) begin
            fin      = 1'b1;
            fin_acc  = trunc_q ? div_rem : (down_q ? acc_dn_q : t_sub[LEN_W-1:0]);
            fin_dest = trunc_q ? run_end[LEN_W-1:0] : col_inc[LEN_W-1:0];
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (row_done) begin
        acc_d  = '0;
        pos_d  = '0;
        dest_d = '0;
      end else begin
        acc_d  = fin_acc;
        pos_d  = pos_q + COL_W'(1);
        dest_d = fin_dest;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      pos_q   <= '0;
      dest_q  <= '0;
      ov_q    <= 1'b0;
      trunc_q <= 1'b0;
      k_q     <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      dest_q  <= dest_d;
      ov_q    <= ov_d;
      trunc_q <= trunc_d;
      k_q     <= k_d;
      t_q     <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q     <= col_d;
    acc_dn_q  <= acc_dn_d;
    down_q    <= down_d;
    trans_q   <= trans_d;
    o_col_q   <= o_col_d;
    o_pix_q   <= o_pix_d;
    o_we_q    <= o_we_d;
    o_lrun_q  <= o_lrun_d;
    o_lrow_q  <= o_lrow_d;
    o_trunc_q <= o_trunc_d;
  end

  assign res.valid         = ov_q;
  assign res.dest_column   = o_col_q;
  assign res.pixel_value   = o_pix_q;
  assign res.write_enable  = o_we_q;
  assign res.last_of_run   = o_lrun_q;
  assign res.last_of_row   = o_lrow_q;
  assign res.run_truncated = o_trunc_q;

  `IRSC_ASSERT(a_emit_has_run, !(state_q == ST_EMIT && !trunc_q) || (t_q >= CNT_W'(s_len)), "run count below one while emitting")
  `IRSC_ASSERT(a_div_done_state, !div_done || (state_q == ST_DIV), "divider finished outside divide phase")
  `IRSC_ASSERT(a_div_long_run, !(div_done && state_q == ST_DIV) || (div_quot > CNT_W'(MAX_RUN)), "divided run not longer than the cap")
  `IRSC_ASSERT_NEXT(a_last_idle, emit && last_w, state_q == ST_IDLE, "sequencer not idle after last word of run")

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Row scaler testbench
// Loads the colour map and streams source rows through the scaler under a
// range of length and transparency settings. A scoreboard predicts every
// scaled output word and checks them in order. Both channels idle at random,
// and the output side once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import irsc_pkg::*;

  localparam int RANDOM_ITEMS   = 330;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_TRANS_IX + CFG_IDX_W'(1);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             we;
    logic             run_end;
    logic             row_end;
    logic             cut;
  } out_word_t;

  class scaled_pixel_board;
    logic [PIX_W-1:0] cmap [256];
    int unsigned src_len, tgt_len, trans_en, trans_idx;
    int unsigned err_acc, src_pos, dst_pos;
    out_word_t   due [$];
    int          faults, words_out, cut_words, clear_words;

    function new();
      foreach (cmap[i]) cmap[i] = '0;
      src_len = 1;
      tgt_len = 1;
      trans_en = 0;
      trans_idx = 0;
      err_acc = 0;
      src_pos = 0;
      dst_pos = 0;
      faults = 0;
      words_out = 0;
      cut_words = 0;
      clear_words = 0;
    endfunction

    static function int unsigned clamp_len(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
      case (idx)
        REG_SRC_LEN:  src_len = 32'(val);
        REG_TGT_LEN:  tgt_len = 32'(val);
        REG_TRANS_EN: trans_en = 32'(val[0]);
        REG_TRANS_IX: trans_idx = 32'(val[PIX_W-1:0]);
        default: ;
      endcase
    endfunction

    // one accepted request word in, its scaled output words queued
    function void note_word(logic kind, logic [PIX_W-1:0] addr, logic [PIX_W-1:0] data,
                            logic [PIX_W-1:0] pix);
      int unsigned s, d, acc, count, emit, run_end, col;
      logic see_through, cut;
      logic [PIX_W-1:0] value;
      out_word_t w;
      if (kind == REQ_MAP) begin
        cmap[addr] = data;
        return;
      end
      s = clamp_len(src_len);
      d = clamp_len(tgt_len);
      acc = err_acc;
      if (s > d) begin
        if (acc < d) begin
          count = 1;
          acc = acc + s - d;
        end else begin
          count = 0;
          acc = acc - d;
        end
      end else begin
        count = (acc + d) / s;
        acc = (acc + d) % s;
      end
      see_through = (trans_en != 0) && (pix == trans_idx);
      value = see_through ? '0 : cmap[pix];
      cut = count > MAX_RUN;
      emit = cut ? MAX_RUN : count;
      run_end = dst_pos + count;
      for (int unsigned k = 0; k < emit; k++) begin
        col = dst_pos + k;
        w.col = COL_W'(col);
        w.value = value;
        w.we = !see_through;
        w.run_end = (k + 1 == emit);
        // a cut run still closes the row if its dropped tail held the last column
        w.row_end = (col + 1 == d) ||
                    ((k + 1 == emit) && cut && dst_pos < d && run_end >= d);
        w.cut = cut;
        due.push_back(w);
      end
      if (src_pos + 1 >= s) begin
        err_acc = 0;
        src_pos = 0;
        dst_pos = 0;
      end else begin
        err_acc = acc & 32'h1FFF;
        src_pos = (src_pos + 1) & 32'hFFF;
        dst_pos = run_end & 32'h1FFF;
      end
    endfunction

    function void check_pixel(out_word_t got);
      out_word_t exp;
      words_out++;
      if (got.cut) cut_words++;
      if (!got.we) clear_words++;
      if (due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected word col=%0d val=%0d we=%0b run=%0b row=%0b cut=%0b",
                   $realtime, got.col, got.value, got.we, got.run_end, got.row_end, got.cut);
        return;
      end
      exp = due.pop_front();
      if (got !== exp) begin
        faults++;
        if (faults <= 10) begin
          $write("%0t: mismatch exp col=%0d val=%0d we=%0b run=%0b row=%0b cut=%0b",
                 $realtime, exp.col, exp.value, exp.we, exp.run_end, exp.row_end, exp.cut);
          $display(" / got col=%0d val=%0d we=%0b run=%0b row=%0b cut=%0b",
                   got.col, got.value, got.we, got.run_end, got.row_end, got.cut);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  irsc_cfg_if cfg_if ();
  irsc_req_if req_if ();
  irsc_res_if res_if ();

  indexed_row_scaler_with_colormap DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #5 clk = ~clk;

  scaled_pixel_board sb = new();

  logic [PIX_W-1:0] loaded [$];
  bit               loaded_flag [256];
  bit               no_gaps;
  int               items, map_items, settings;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // only entries already loaded, or the transparent index, may be sent
  function automatic logic [PIX_W-1:0] pick_pixel();
    if (sb.trans_en != 0 && $urandom_range(0, 5) == 0) return PIX_W'(sb.trans_idx);
    return loaded[$urandom_range(0, loaded.size() - 1)];
  endfunction

  task automatic send_word(logic kind, logic [PIX_W-1:0] addr, logic [PIX_W-1:0] data,
                           logic [PIX_W-1:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.map_address <= addr;
    req_if.map_data    <= data;
    req_if.pixel_index <= pix;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_word(kind, addr, data, pix);
    items++;
    if (kind == REQ_MAP) begin
      map_items++;
      if (!loaded_flag[addr]) begin
        loaded_flag[addr] = 1'b1;
        loaded.push_back(addr);
      end
    end
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.set_reg(idx, val);
  endtask

  task automatic cfg_end();
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  task automatic wait_idle();
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side: random stalls plus a long hold-off while the input is backed up
  initial begin
    int stall, hold, got;
    bit held;
    out_word_t w;
    stall = 0;
    hold = 0;
    got = 0;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        w.col = res_if.dest_column;
        w.value = res_if.pixel_value;
        w.we = res_if.write_enable;
        w.run_end = res_if.last_of_run;
        w.row_end = res_if.last_of_row;
        w.cut = res_if.run_truncated;
        sb.check_pixel(w);
        got++;
      end
      if (!held && got >= 300 && req_if.valid === 1'b1 && req_if.ready !== 1'b1) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (stall > 0) begin
          stall--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int rnd_items, n, r, len_s, len_t;
    logic [PIX_W-1:0] mix [7];
    rnd_items = 0;
    no_gaps = 1'b0;
    rst_n <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    req_if.valid <= 1'b0;
    req_if.req_type <= REQ_MAP;
    req_if.map_address <= '0;
    req_if.map_data <= '0;
    req_if.pixel_index <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // upscale 5 -> 11 with transparency, map loads at the extremes
    cfg_put(REG_SRC_LEN, LEN_W'(5));
    cfg_put(REG_TGT_LEN, LEN_W'(11));
    cfg_put(REG_TRANS_EN, LEN_W'(1));
    cfg_put(REG_TRANS_IX, LEN_W'(8'h5A));
    cfg_put(REG_SPARE, 13'h1FFF);
    cfg_end();
    send_word(REQ_MAP, 8'h00, 8'hFF, 8'h00);
    send_word(REQ_MAP, 8'hFF, 8'h00, 8'hFF);
    send_word(REQ_MAP, 8'h3C, 8'hA5, 8'h00);
    send_word(REQ_MAP, 8'hC3, 8'h5A, 8'hFF);
    send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'h00);
    send_word(REQ_PIXEL, 8'h00, 8'h00, 8'hFF);
    send_word(REQ_PIXEL, 8'h00, 8'h00, 8'h5A);
    send_word(REQ_PIXEL, 8'h00, 8'h00, 8'h3C);
    send_word(REQ_PIXEL, 8'h00, 8'h00, 8'hC3);
    req_if.valid <= 1'b0;

    // downscale 7 -> 3, transparency off
    wait_idle();
    cfg_put(REG_SRC_LEN, LEN_W'(7));
    cfg_put(REG_TGT_LEN, LEN_W'(3));
    cfg_put(REG_TRANS_EN, LEN_W'(0));
    cfg_end();
    mix = '{8'h00, 8'hFF, 8'h3C, 8'hC3, 8'h00, 8'hFF, 8'h3C};
    foreach (mix[i]) send_word(REQ_PIXEL, '0, '0, mix[i]);
    req_if.valid <= 1'b0;

    // 2 -> 130: both runs cut, the second one's dropped tail holds the row end
    wait_idle();
    cfg_put(REG_SRC_LEN, LEN_W'(2));
    cfg_put(REG_TGT_LEN, LEN_W'(130));
    cfg_put(REG_TRANS_EN, LEN_W'(1));
    cfg_end();
    send_word(REQ_PIXEL, '0, '0, 8'h3C);
    send_word(REQ_PIXEL, '0, '0, 8'h5A);
    req_if.valid <= 1'b0;

    wait_idle();
    cfg_put(REG_SRC_LEN, LEN_W'(1));
    cfg_put(REG_TGT_LEN, LEN_W'(4096));
    cfg_end();
    send_word(REQ_PIXEL, '0, '0, 8'hFF);
    req_if.valid <= 1'b0;

    // zero lengths act as one
    wait_idle();
    cfg_put(REG_SRC_LEN, LEN_W'(0));
    cfg_put(REG_TGT_LEN, LEN_W'(0));
    cfg_end();
    send_word(REQ_PIXEL, '0, '0, 8'h00);
    req_if.valid <= 1'b0;

    // oversize lengths clamp to the row limit
    wait_idle();
    cfg_put(REG_SRC_LEN, 13'h1FFF);
    cfg_put(REG_TGT_LEN, 13'h1FFF);
    cfg_end();
    send_word(REQ_PIXEL, '0, '0, 8'hC3);
    send_word(REQ_PIXEL, '0, '0, 8'h5A);
    req_if.valid <= 1'b0;

    wait_idle();
    cfg_put(REG_SRC_LEN, LEN_W'(4096));
    cfg_put(REG_TGT_LEN, LEN_W'(1));
    cfg_end();
    send_word(REQ_PIXEL, '0, '0, 8'hFF);
    req_if.valid <= 1'b0;

    while (rnd_items < RANDOM_ITEMS) begin
      wait_idle();
      r = $urandom_range(0, 9);
      if (r < 6) begin
        len_s = $urandom_range(1, 12);
        len_t = $urandom_range(1, 24);
      end else if (r < 8) begin
        len_s = $urandom_range(1, 4);
        len_t = $urandom_range(60, 300);
      end else if (r == 8) begin
        len_s = $urandom_range(20, 80);
        len_t = $urandom_range(1, 10);
      end else begin
        len_s = $urandom_range(0, 8191);
        len_t = $urandom_range(0, 8191);
      end
      // some settings leave a register alone, so rows carry across
      if ($urandom_range(0, 3) != 0) cfg_put(REG_SRC_LEN, LEN_W'(len_s));
      if ($urandom_range(0, 3) != 0) cfg_put(REG_TGT_LEN, LEN_W'(len_t));
      if ($urandom_range(0, 3) != 0) cfg_put(REG_TRANS_EN, LEN_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0)
        cfg_put(REG_TRANS_IX, $urandom_range(0, 1) ? LEN_W'(pick_pixel())
                                                   : LEN_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0)
        cfg_put(CFG_IDX_W'($urandom_range(REG_SPARE, (1 << CFG_IDX_W) - 1)),
                LEN_W'($urandom_range(0, 8191)));
      cfg_end();
      no_gaps = ($urandom_range(0, 3) == 0);
      len_s = scaled_pixel_board::clamp_len(sb.src_len);
      n = (len_s <= 16) ? len_s * $urandom_range(1, 3) : $urandom_range(8, 30);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          send_word(REQ_MAP, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                    PIX_W'($urandom_range(0, 255)));
          rnd_items++;
        end
        send_word(REQ_PIXEL, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                  pick_pixel());
        rnd_items++;
      end
      req_if.valid <= 1'b0;
    end

    wait_idle();
    $display("Covered %0d request words (%0d map loads) over %0d register settings.",
             items, map_items, settings);
    $display("Checked %0d output words: %0d from cut runs, %0d transparent.",
             sb.words_out, sb.cut_words, sb.clear_words);
    if (sb.faults == 0 && sb.due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
